>>> rtl/btrm_pkg.sv
// Shared widths, register map and port constants for the buddy tree range marker.
package btrm_pkg;

  localparam int START_W = 8;
  localparam int LEN_W   = 9;
  localparam int CFG_W   = 9;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register map, index taken from paddr[2]
  localparam logic [APB_AW-3:0] REG_LEAVES_IN_USE = 1'b0;

  localparam logic [CFG_W-1:0] LEAVES_RESET = 9'd256;

endpackage

>>> rtl/btrm_node_ram.sv
// Node bit store: one write port, two registered read ports, write-first.
module btrm_node_ram import btrm_pkg::*; #(
  parameter int DEPTH = 511,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic          rdata_a,
  output logic          rdata_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-address write in the same cycle is returned on the read side
  always_ff @(posedge clk) begin
    rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

endmodule

>>> rtl/btrm_cfg_regs.sv
// APB register block holding leaves_in_use.
module btrm_cfg_regs import btrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CFG_W-1:0]  leaves_in_use
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[APB_AW-1:2] == REG_LEAVES_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      leaves_in_use <= LEAVES_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      leaves_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = hit ? {{(APB_DW-CFG_W){1'b0}}, leaves_in_use} : '0;

endmodule

>>> rtl/buddy_tree_range_mark.sv
// Top level: sequencer that marks leaf runs and walks the buddy tree in node memory.
//
// Usage
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one request item: a run of
//   leaves to mark taken. Master stream (m_tvalid/m_tready/m_tdata) returns one
//   result item per request: the error flag and the root (pool full) bit.
//   The APB port sets leaves_in_use; write it only while no request is in flight.
// Sequence
//   One request at a time. A zero-length or failing request goes straight to
//   the root read and the result. Otherwise each leaf of the run is written,
//   then the parents over the run on every level up to the root are updated,
//   at most LEAF_COUNT-1 of them, and the root is read for the result. Each
//   leaf write and each parent update goes through the single write port of
//   the node memory. s_tready returns high at the edge that loads the result,
//   so a new item is never taken before the result is loaded.
// Reset
//   rst clears control state, then a clearing pass zeroes all 2*LEAF_COUNT-1
//   words of node memory; s_tready stays low throughout. APB stays usable.
// Stall
//   The result sits in an output register; a new request can be accepted and
//   worked on while it waits. A finished request holds in the last state
//   until the output register frees.
module buddy_tree_range_mark import btrm_pkg::*; #(
  parameter int LEAF_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] range_start, [16:8] range_length, rest 0
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [0] range_error, [1] pool_full, rest 0
);

  localparam int LW    = $clog2(LEAF_COUNT);
  localparam int AW    = LW + 1;
  localparam int DEPTH = 2 * LEAF_COUNT - 1;
  localparam int CMPW  = (LW + 1 > LEN_W + 1) ? LW + 1 : LEN_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LEAF  = 3'd2;
  localparam logic [2:0] ST_NODE  = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [AW-1:0] ROOT_ADDR = '0;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LEAF_BASE = AW'(LEAF_COUNT - 1);

  logic [2:0]         state;
  logic [CFG_W-1:0]   leaves_in_use;

  // request fields
  logic [START_W-1:0] range_start;
  logic [LEN_W-1:0]   range_length;
  logic [CMPW-1:0]    lim;
  logic [CMPW-1:0]    start_ext;
  logic [CMPW-1:0]    run_end;
  logic [CMPW-1:0]    run_last;
  logic               req_error;
  logic               accept;

  // walk registers
  logic [AW-1:0]      clr_cnt;
  logic [LW-1:0]      orig_lo;
  logic [LW-1:0]      lo;
  logic [LW-1:0]      hi;
  logic [LW-1:0]      p;
  logic [AW-1:0]      base;
  logic [CMPW-1:0]    span;
  logic [CMPW-1:0]    first;
  logic               err_q;

  // read-to-write stage for parent updates
  logic               v1;
  logic [AW-1:0]      node_q;
  logic [CMPW-1:0]    first_l_q;
  logic [CMPW-1:0]    first_r_q;

  logic [AW-1:0]      node;
  logic [AW-1:0]      left;
  logic [CMPW-1:0]    span_up;
  logic               node_is_full;

  // memory ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic               rdata_a;
  logic               rdata_b;

  logic               out_free;

  btrm_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .leaves_in_use (leaves_in_use)
  );

  btrm_node_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign range_start  = s_tdata[START_W-1:0];
  assign range_length = s_tdata[START_W+LEN_W-1:START_W];

  // effective pool size, saturated at the tree width
  assign lim = (CMPW'(leaves_in_use) > CMPW'(LEAF_COUNT)) ? CMPW'(LEAF_COUNT)
                                                          : CMPW'(leaves_in_use);
  assign start_ext = CMPW'(range_start);
  assign run_end   = start_ext + CMPW'(range_length);
  assign run_last  = run_end - CMPW'(1);
  assign req_error = (range_length != '0) && (run_end > lim);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // parent at (base, p); its children sit at 2*node+1 and 2*node+2
  assign node    = base + AW'(p);
  assign left    = {node[LW-1:0], 1'b1};
  assign span_up = span << 1;

  // a child beyond the pool counts as full whatever its stored bit
  assign node_is_full = ((first_l_q >= lim) || rdata_a) && ((first_r_q >= lim) || rdata_b);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 1'b0;
      end
      ST_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = node;
      end
      default: begin
        ram_we = v1 && node_is_full;
      end
    endcase
  end

  always_comb begin
    raddr_a = left;
    raddr_b = left + AW'(1);
    if (state == ST_ROOT || state == ST_FIN) begin
      raddr_a = ROOT_ADDR;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      v1 <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_error || (range_length == '0)) begin
              state <= ST_ROOT;
            end else begin
              state <= ST_LEAF;
            end
          end
        end
        ST_LEAF: begin
          if (p == hi) begin
            state <= ST_NODE;
          end
        end
        ST_NODE: begin
          v1 <= 1'b1;
          if (p == hi && base == '0) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    node_q    <= node;
    first_l_q <= first;
    first_r_q <= first + (span >> 1);
    unique case (state)
      ST_IDLE: begin
        err_q   <= req_error;
        orig_lo <= start_ext[LW-1:0];
        lo      <= start_ext[LW-1:0];
        p       <= start_ext[LW-1:0];
        hi      <= run_last[LW-1:0];
        base    <= LEAF_BASE;
        span    <= CMPW'(1);
      end
      ST_LEAF, ST_NODE: begin
        if (p == hi) begin
          // step up one level over the same run
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          p     <= lo >> 1;
          base  <= base >> 1;
          span  <= span_up;
          first <= CMPW'(orig_lo) & ~(span_up - CMPW'(1));
        end else begin
          p     <= p + LW'(1);
          first <= first + span;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {{(M_TDATA_W-2){1'b0}}, rdata_a || (lim == '0), err_q};
    end
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request accepted while previous one in flight");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("node memory written while idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr <= LAST_ADDR))
    else $error("node memory write beyond tree");

  a_stage_in_walk: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (state == ST_NODE || state == ST_ROOT))
    else $error("parent update outside tree walk");

endmodule

>>> bench/tb.sv
// Self-checking bench for the buddy tree range marker: streams runs, predicts tree state.
`timescale 1ns / 1ps

module tb import btrm_pkg::*; ();

  localparam int LEAVES = 256;
  localparam int NODES  = 2 * LEAVES - 1;

  // One result item as the block packs it: [0] range_error, [1] pool_full
  typedef struct packed {
    logic pool_full;
    logic range_error;
  } mark_result_t;

  // Scoreboard: shadow copy of the full-bit tree plus the results still owed
  class range_mark_board;
    bit node_full [0:NODES-1];
    bit [CFG_W-1:0] leaves_reg;
    mark_result_t outstanding [$];
    int failures;

    function new();
      foreach (node_full[i]) node_full[i] = 1'b0;
      leaves_reg = LEAVES_RESET;
      failures = 0;
    endfunction

    function void set_leaves(bit [CFG_W-1:0] v);
      leaves_reg = v;
    endfunction

    // A node is full if its bit is set or it starts past the pool end
    function bit taken(int unsigned idx, int unsigned first_leaf, int unsigned lim);
      if (first_leaf >= lim) return 1'b1;
      if (idx >= NODES) return 1'b1;
      return node_full[idx];
    endfunction

    // Mark the run, walk up the tree, queue the result it owes
    function void note_request(bit [START_W-1:0] start, bit [LEN_W-1:0] len);
      int unsigned lim, lo, hi, n, span, base, node, left;
      mark_result_t res;
      lim = (leaves_reg > LEAVES) ? LEAVES : leaves_reg;
      lo = start;
      hi = lo + len - 1;
      res.range_error = 1'b0;
      if (len != 0) begin
        if (lo + len > lim) begin
          res.range_error = 1'b1;
        end else begin
          for (int unsigned b = lo; b <= hi; b++) node_full[LEAVES - 1 + b] = 1'b1;
          n = LEAVES;
          span = 1;
          while (n > 1) begin
            n = n >> 1;
            span = span << 1;
            lo = lo >> 1;
            hi = hi >> 1;
            base = n - 1;
            for (int unsigned p = lo; p <= hi; p++) begin
              node = base + p;
              left = 2 * node + 1;
              if (taken(left, p * span, lim) && taken(left + 1, p * span + span / 2, lim))
                node_full[node] = 1'b1;
            end
          end
        end
      end
      res.pool_full = node_full[0] || (lim == 0);
      outstanding.push_back(res);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata);
      mark_result_t want;
      if (outstanding.size() == 0) begin
        $display("%0t: result item %b arrived with nothing expected", $time, tdata);
        failures++;
        return;
      end
      want = outstanding.pop_front();
      if (tdata[0] !== want.range_error) begin
        $display("%0t: range_error expected %b, got %b", $time, want.range_error, tdata[0]);
        failures++;
      end
      if (tdata[1] !== want.pool_full) begin
        $display("%0t: pool_full expected %b, got %b", $time, want.pool_full, tdata[1]);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel, penable, pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [7:0] range_start, [16:8] range_length, rest 0
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [0] range_error, [1] pool_full, rest 0

  bit allow_idle;                  // random gaps on both streams while set
  range_mark_board board = new();

  // Pool sizes visited by the random phases: saturation, odd sizes, tiny pools,
  // an empty pool, then back to a full pool for the closing run
  int phase_cfg [13] = '{256, 511, 300, 200, 170, 85, 129, 64, 37, 8, 1, 0, 256};

  buddy_tree_range_mark #(.LEAF_COUNT(LEAVES)) uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: reports a failure and stops the run if the regression hangs
  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: accepted items go straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Result side back-pressure: random bursts of stalls while idling is on
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && allow_idle && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Offer one request item and hold it until taken; maybe idle afterwards.
  // Valid stays high into the next call when no gap is taken.
  task automatic send_request(input bit [START_W-1:0] start, input bit [LEN_W-1:0] len);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, len, start};
    do @(posedge clk); while (!s_tready);
    board.note_request(start, len);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed result come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.outstanding.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write to leaves_in_use: setup cycle then access cycle
  task automatic write_leaves(input bit [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LEAVES_IN_USE, 2'b00};
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_leaves(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random phase: mostly runs that fit the pool with short lengths, so the
  // tree fills gradually; the rest is zero-length and overrunning items
  task automatic run_phase(input int cfg, input int count);
    int unsigned lim, room, lo_len, dice, pick;
    bit [START_W-1:0] start;
    bit [LEN_W-1:0] len;
    lim = (cfg > LEAVES) ? LEAVES : cfg;
    for (int k = 0; k < count; k++) begin
      dice = $urandom_range(0, 99);
      if (dice < 5) begin
        start = START_W'($urandom_range(0, 255));
        len = '0;
      end else if (dice < 15 || lim == 0) begin
        // overrun: start+len past the pool end
        start = START_W'($urandom_range(0, 255));
        if (start == 0 && lim == LEAVES) start = 8'd1;
        lo_len = (lim > start) ? lim - start + 1 : 1;
        len = LEN_W'($urandom_range(lo_len, LEAVES));
      end else begin
        start = START_W'($urandom_range(0, lim - 1));
        room = lim - start;
        pick = $urandom_range(0, 99);
        if (pick < 70) len = LEN_W'($urandom_range(1, 3));
        else if (pick < 97) len = LEN_W'($urandom_range(1, 24));
        else len = LEN_W'(room);
        if (len > room) len = LEN_W'(room);
      end
      send_request(start, len);
    end
  endtask

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    allow_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    allow_idle = 1'b1;

    // Directed: pool at its reset size of 256 leaves. The tree clearing pass
    // runs first; s_tready holds the first item off until it is done.
    send_request(8'd0, 9'd0);       // zero length, root still clear
    send_request(8'd255, 9'd0);
    send_request(8'd255, 9'd1);     // last leaf
    send_request(8'd0, 9'd1);
    send_request(8'd1, 9'd1);       // sibling completes a parent
    send_request(8'd2, 9'd2);
    send_request(8'd4, 9'd4);
    send_request(8'd1, 9'd256);     // longest run, overruns
    send_request(8'd255, 9'd2);     // overrun by one
    send_request(8'd192, 9'd63);    // fills the top quarter with leaf 255
    drain();

    // Empty pool: every nonempty run fails, root reads full
    write_leaves(9'd0);
    send_request(8'd0, 9'd0);
    send_request(8'd0, 9'd1);
    send_request(8'd255, 9'd256);
    drain();

    // Register above the leaf count saturates to 256
    write_leaves(9'd511);
    send_request(8'd8, 9'd8);
    send_request(8'd200, 9'd57);    // ends at 257: overrun
    send_request(8'd64, 9'd16);

    // Random phases; every boundary waits for all results (sender pause).
    // Idling is off in every fourth phase and throughout the last one.
    for (int i = 0; i < 13; i++) begin
      drain();
      write_leaves(CFG_W'(phase_cfg[i]));
      allow_idle = (i % 4 != 2) && (i != 12);
      run_phase(phase_cfg[i], 80);
    end

    // Closing run: whole pool in one item
    send_request(8'd0, 9'd256);
    s_tvalid <= 1'b0;

    while (board.outstanding.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.outstanding.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> buddy_tree_range_mark.f
rtl/btrm_pkg.sv
rtl/btrm_node_ram.sv
rtl/btrm_cfg_regs.sv
rtl/buddy_tree_range_mark.sv
bench/tb.sv
